>>> design/magnetometer_heading_magnitude_assert.svh
`ifndef MAGNETOMETER_HEADING_MAGNITUDE_ASSERT_SVH
`define MAGNETOMETER_HEADING_MAGNITUDE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define MHM_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// implication whose property is checked in the cycle after the condition
`define MHM_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> design/mhm_pkg.sv
package mhm_pkg;

    localparam int AXIS_W   = 16;
    localparam int DIFF_W   = 17;
    localparam int FIELD_W  = 19;
    localparam int MAG_W    = 19;
    localparam int BEAR_W   = 15;
    localparam int SQ_W     = 34;
    localparam int SUM_W    = 36;
    localparam int RAD_W    = 40;
    localparam int ROOT_W   = 20;
    localparam int REM_W    = 23;
    localparam int CORD_W   = 44;
    localparam int ACC_W    = 32;
    localparam int PRESHIFT = 24;
    localparam int ATAN_LEN = 24;

    localparam logic [ACC_W-1:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [ACC_W-1:0] TURN_HALF    = 32'h8000_0000;
    localparam logic [ACC_W-1:0] TURN_3Q      = 32'hC000_0000;

    localparam logic [ACC_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef enum logic [1:0] {
        REG_X_OFFSET = 2'd0,
        REG_Y_OFFSET = 2'd1,
        REG_Z_OFFSET = 2'd2,
        REG_NONE     = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] dz;
        logic [RAD_W-1:0]         rad;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
        logic signed [CORD_W-1:0] u;
        logic signed [CORD_W-1:0] v;
        logic [ACC_W-1:0]         acc;
        logic                     fixed_angle;
    } mhm_item_t;

endpackage

>>> design/magnetometer_heading_magnitude.sv
// magnetometer heading and field magnitude
// input channel: in_valid/in_ready with x_raw, y_raw, z_raw (signed counts)
// output channel: out_valid/out_ready with x_field, y_field, z_field (corrected
//   count times 3), field_magnitude (isqrt of 9 * sum of squares) and bearing
//   (atan2(y, -x) in 1/2^ANGLE_FRAC_BITS degree, [0,360))
// configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
//   always high, index 0/1/2 writes the x/y/z hard-iron offset, others ignored
// throughput: one transaction per cycle while out_ready is high, fully pipelined
// path: out_valid follows the input transaction through the front registers,
//   the cell chain and the back registers; the chain length is set by the 20
//   square-root cells, or by the CORDIC cells when there are more of them
// every stage has its own valid bit, so a stalled receiver only fills the
//   pipeline; in_ready drops once every stage holds a transaction
// reset clears all valid bits and loads the offsets -26, 256 and 10
module magnetometer_heading_magnitude #(
    parameter int ANGLE_FRAC_BITS = 6,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mhm_pkg::AXIS_W-1:0]      x_raw,
    input  logic signed [mhm_pkg::AXIS_W-1:0]      y_raw,
    input  logic signed [mhm_pkg::AXIS_W-1:0]      z_raw,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mhm_pkg::FIELD_W-1:0]     x_field,
    output logic signed [mhm_pkg::FIELD_W-1:0]     y_field,
    output logic signed [mhm_pkg::FIELD_W-1:0]     z_field,
    output logic [mhm_pkg::MAG_W-1:0]              field_magnitude,
    output logic [mhm_pkg::BEAR_W-1:0]             bearing,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [1:0]                             cfg_index,
    input  logic [mhm_pkg::AXIS_W-1:0]             cfg_data
);
    import mhm_pkg::*;

    localparam int NCELL  = (CORDIC_STAGES > ROOT_W) ? CORDIC_STAGES : ROOT_W;
    localparam int FULL_W = 9 + ANGLE_FRAC_BITS;
    localparam int PROD_W = ACC_W + FULL_W;
    localparam int EXT_W  = FULL_W + BEAR_W + 1;
    localparam logic [FULL_W-1:0] FULL = FULL_W'(360) << ANGLE_FRAC_BITS;

    logic signed [AXIS_W-1:0] x_off_reg, y_off_reg, z_off_reg;

    // front stages
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic r1, r2, r3, r4, r5;
    logic signed [DIFF_W-1:0] dx1_reg, dy1_reg, dz1_reg;
    logic signed [DIFF_W-1:0] dx2_reg, dy2_reg, dz2_reg;
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg;
    mhm_item_t item3_next, item3_reg;
    logic [SUM_W-1:0] sum3;

    // chain
    logic      ch_valid [NCELL+1];
    logic      ch_ready [NCELL+1];
    mhm_item_t ch_item  [NCELL+1];

    // back stages
    logic signed [DIFF_W-1:0] dx4_reg, dy4_reg, dz4_reg;
    logic [MAG_W-1:0]  mag4_reg;
    logic [PROD_W-1:0] prod4_reg;
    logic [EXT_W-1:0]  rnd5;
    logic [EXT_W-1:0]  wrap5;
    logic signed [FIELD_W-1:0] fx5, fy5, fz5;
    logic signed [FIELD_W-1:0] x_field_reg, y_field_reg, z_field_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic [BEAR_W-1:0] bearing_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_off_reg <= -16'sd26;
            y_off_reg <= 16'sd256;
            z_off_reg <= 16'sd10;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_X_OFFSET: x_off_reg <= cfg_data;
                REG_Y_OFFSET: y_off_reg <= cfg_data;
                REG_Z_OFFSET: z_off_reg <= cfg_data;
                REG_NONE:     ;
                default:      ;
            endcase
        end
    end

    // ready chain, each stage frees itself when the next one takes
    assign r5       = !v5_reg || out_ready;
    assign r4       = !v4_reg || r5;
    assign r3       = !v3_reg || ch_ready[0];
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= ch_valid[NCELL];
            if (r5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            dx1_reg <= DIFF_W'(x_raw) - DIFF_W'(x_off_reg);
            dy1_reg <= DIFF_W'(y_raw) - DIFF_W'(y_off_reg);
            dz1_reg <= DIFF_W'(z_raw) - DIFF_W'(z_off_reg);
        end
        if (r2 && v1_reg)
        begin
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            dz2_reg <= dz1_reg;
            sqx_reg <= SQ_W'(dx1_reg * dx1_reg);
            sqy_reg <= SQ_W'(dy1_reg * dy1_reg);
            sqz_reg <= SQ_W'(dz1_reg * dz1_reg);
        end
        if (r3 && v2_reg)
            item3_reg <= item3_next;
    end

    always_comb
    begin
        sum3 = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
        item3_next             = '0;
        item3_next.dx          = dx2_reg;
        item3_next.dy          = dy2_reg;
        item3_next.dz          = dz2_reg;
        item3_next.rad         = {sum3, 3'b000} + RAD_W'(sum3);
        item3_next.fixed_angle = (dx2_reg == '0) || (dy2_reg == '0);
        item3_next.u           = -(CORD_W'(dx2_reg) <<< PRESHIFT);
        item3_next.v           = CORD_W'(dy2_reg) <<< PRESHIFT;
        item3_next.acc         = '0;
        if (dx2_reg == '0)
        begin
            if (dy2_reg == '0)
                item3_next.acc = '0;
            else if (dy2_reg < 0)
                item3_next.acc = TURN_3Q;
            else
                item3_next.acc = TURN_QUARTER;
        end
        else if (dy2_reg == '0)
            item3_next.acc = (dx2_reg > 0) ? TURN_HALF : '0;
        else if (dx2_reg > 0)
        begin
            // mirror into the right half plane
            item3_next.u   = CORD_W'(dx2_reg) <<< PRESHIFT;
            item3_next.v   = -(CORD_W'(dy2_reg) <<< PRESHIFT);
            item3_next.acc = TURN_HALF;
        end
    end

    assign ch_valid[0] = v3_reg;
    assign ch_item[0]  = item3_reg;
    assign ch_ready[NCELL] = r4;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        mhm_cell #(
            .IDX       (i),
            .DO_SQRT   (i < ROOT_W),
            .DO_CORDIC (i < CORDIC_STAGES)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (ch_valid[i]),
            .up_ready (ch_ready[i]),
            .up_item  (ch_item[i]),
            .dn_valid (ch_valid[i+1]),
            .dn_ready (ch_ready[i+1]),
            .dn_item  (ch_item[i+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (r4 && ch_valid[NCELL])
        begin
            dx4_reg   <= ch_item[NCELL].dx;
            dy4_reg   <= ch_item[NCELL].dy;
            dz4_reg   <= ch_item[NCELL].dz;
            mag4_reg  <= ch_item[NCELL].root[MAG_W-1:0];
            prod4_reg <= PROD_W'(ch_item[NCELL].acc) * PROD_W'(FULL);
        end
        if (r5 && v4_reg)
        begin
            x_field_reg <= fx5;
            y_field_reg <= fy5;
            z_field_reg <= fz5;
            mag_reg     <= mag4_reg;
            bearing_reg <= wrap5[BEAR_W-1:0];
        end
    end

    always_comb
    begin
        // round half up to the output step, a full turn wraps to zero
        rnd5  = EXT_W'((PROD_W'(1) + PROD_W'(prod4_reg) + PROD_W'(32'h7FFF_FFFF)) >> ACC_W);
        wrap5 = (rnd5 >= EXT_W'(FULL)) ? rnd5 - EXT_W'(FULL) : rnd5;
        fx5   = (FIELD_W'(dx4_reg) <<< 1) + FIELD_W'(dx4_reg);
        fy5   = (FIELD_W'(dy4_reg) <<< 1) + FIELD_W'(dy4_reg);
        fz5   = (FIELD_W'(dz4_reg) <<< 1) + FIELD_W'(dz4_reg);
    end

    assign out_valid       = v5_reg;
    assign x_field         = x_field_reg;
    assign y_field         = y_field_reg;
    assign z_field         = z_field_reg;
    assign field_magnitude = mag_reg;
    assign bearing         = bearing_reg;

endmodule

>>> design/mhm_cell.sv
module mhm_cell #(
    parameter int IDX       = 0,
    parameter bit DO_SQRT   = 1'b1,
    parameter bit DO_CORDIC = 1'b1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  mhm_pkg::mhm_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output mhm_pkg::mhm_item_t dn_item
);
    import mhm_pkg::*;

    logic      valid_reg;
    mhm_item_t item_reg;
    mhm_item_t item_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic signed [CORD_W-1:0] su;
    logic signed [CORD_W-1:0] sv;

    always_comb
    begin
        item_next = up_item;
        rem_sh    = {up_item.rem[REM_W-3:0], up_item.rad[RAD_W-1 -: 2]};
        trial     = {1'b0, up_item.root, 2'b01};
        su        = up_item.u >>> IDX;
        sv        = up_item.v >>> IDX;
        if (DO_SQRT)
        begin
            item_next.rad = {up_item.rad[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                item_next.rem  = rem_sh - trial;
                item_next.root = {up_item.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                item_next.rem  = rem_sh;
                item_next.root = {up_item.root[ROOT_W-2:0], 1'b0};
            end
        end
        if (DO_CORDIC && !up_item.fixed_angle)
        begin
            // turn the vector towards the positive u axis
            if (up_item.v > 0)
            begin
                item_next.u   = up_item.u + sv;
                item_next.v   = up_item.v - su;
                item_next.acc = up_item.acc + ATAN_TURNS[IDX];
            end
            else
            begin
                item_next.u   = up_item.u - sv;
                item_next.v   = up_item.v + su;
                item_next.acc = up_item.acc - ATAN_TURNS[IDX];
            end
        end
    end

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (up_ready)
            valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
            item_reg <= item_next;
    end

endmodule

>>> design/mhm_checker.sv
`include "magnetometer_heading_magnitude_assert.svh"

module mhm_checker #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [mhm_pkg::FIELD_W-1:0] x_field,
    input logic signed [mhm_pkg::FIELD_W-1:0] y_field,
    input logic signed [mhm_pkg::FIELD_W-1:0] z_field,
    input logic [mhm_pkg::MAG_W-1:0]          field_magnitude,
    input logic [mhm_pkg::BEAR_W-1:0]         bearing
);
    import mhm_pkg::*;

    localparam int QW = BEAR_W + 11;
    localparam logic [QW-1:0] DEG90  = QW'(90) << ANGLE_FRAC_BITS;
    localparam logic [QW-1:0] DEG270 = QW'(270) << ANGLE_FRAC_BITS;

    `MHM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `MHM_ASSERT_IMP(a_zero_xy, clk, rst_n, out_valid && x_field == '0 && y_field == '0, bearing == '0, "bearing of zero vector not zero")
    `MHM_ASSERT_IMP(a_zero_mag, clk, rst_n, out_valid && x_field == '0 && y_field == '0 && z_field == '0, field_magnitude == '0, "magnitude of zero field not zero")
    `MHM_ASSERT_IMP(a_axis_y, clk, rst_n, out_valid && x_field == '0 && y_field != '0, QW'(bearing) == (DEG90 & QW'({BEAR_W{1'b1}})) || QW'(bearing) == (DEG270 & QW'({BEAR_W{1'b1}})), "bearing on y axis not a right angle")

endmodule

bind magnetometer_heading_magnitude mhm_checker #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_mhm_checker (.*);
